FILE: rtl/core/ule_pkg.sv
// ----------------------------------------------------------------------------
// ule_pkg
// Shared types, codes, microprogram and UTF-8 encoder for the line-edit buffer.
// ----------------------------------------------------------------------------
package ule_pkg;

  // Field widths of the stream payloads
  localparam int unsigned CMD_W = 3;
  localparam int unsigned CP_W  = 21;
  localparam int unsigned POS_W = 11;
  localparam int unsigned OUT_W = 11;

  // UTF-8 constants
  localparam logic [7:0]      CONT_MASK  = 8'hC0;
  localparam logic [7:0]      CONT_TAG   = 8'h80;
  localparam logic [CP_W-1:0] CP_LIM_1B  = 21'h00_0080;
  localparam logic [CP_W-1:0] CP_LIM_2B  = 21'h00_0800;
  localparam logic [CP_W-1:0] CP_LIM_3B  = 21'h01_0000;
  localparam logic [CP_W-1:0] CP_LIM_4B  = 21'h11_0000;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_LEFT      = 3'd1,
    CMD_RIGHT     = 3'd2,
    CMD_BACKSPACE = 3'd3,
    CMD_DELETE    = 3'd4,
    CMD_SET_CUR   = 3'd5,
    CMD_READ      = 3'd6,
    CMD_NOTHING   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOOP    = 2'd3
  } status_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_N_ZERO      = 4'd2,
    C_FULL        = 4'd3,
    C_PTR_EQ_CUR  = 4'd4,
    C_PTR_NE_CUR  = 4'd5,
    C_E_NE_N      = 4'd6,
    C_CUR_GE_LEN  = 4'd7,
    C_CUR_ZERO    = 4'd8,
    C_NOT_CONT    = 4'd9,
    C_CURK_GE_LEN = 4'd10,
    C_PTRK_GE_LEN = 4'd11,
    C_POS_GE_LEN  = 4'd12
  } cond_t;

  typedef enum logic [1:0] {
    CUR_HOLD    = 2'd0,
    CUR_INC     = 2'd1,
    CUR_DEC     = 2'd2,
    CUR_SET_POS = 2'd3
  } cur_op_t;

  typedef enum logic [1:0] {
    LEN_HOLD  = 2'd0,
    LEN_ADD_K = 2'd1,
    LEN_SUB_K = 2'd2
  } len_op_t;

  typedef enum logic [2:0] {
    PTR_HOLD     = 3'd0,
    PTR_LOAD_LEN = 3'd1,
    PTR_LOAD_CUR = 3'd2,
    PTR_DEC      = 3'd3,
    PTR_INC      = 3'd4
  } ptr_op_t;

  typedef enum logic [1:0] {
    K_HOLD = 2'd0,
    K_ONE  = 2'd1,
    K_INC  = 2'd2
  } k_op_t;

  // Read address select
  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_PTR_M1 = 3'd1,
    RD_CUR    = 3'd2,
    RD_CURK   = 3'd3,
    RD_PTRK   = 3'd4,
    RD_POS    = 3'd5
  } rd_sel_t;

  // Write address and data select
  typedef enum logic [1:0] {
    WR_NONE     = 2'd0,
    WR_PTRK_RD  = 2'd1,
    WR_CURE_ENC = 2'd2,
    WR_PTR_RD   = 2'd3
  } wr_sel_t;

  typedef logic [5:0] uaddr_t;

  // One control word; the status write only takes effect when the jump is taken
  typedef struct packed {
    cond_t   cond;
    uaddr_t  target;
    cur_op_t cur_op;
    len_op_t len_op;
    ptr_op_t ptr_op;
    k_op_t   k_op;
    logic    e_inc;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    st_en;
    status_t st_val;
    logic    rb_load;
    logic    fin;
  } ucode_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic   start;
    logic   taken;
    ucode_t word;
  } dp_ctrl_t;

  // Conditions from the datapath to the sequencer
  typedef struct packed {
    logic n_zero;
    logic full;
    logic ptr_eq_cur;
    logic e_last;
    logic cur_ge_len;
    logic cur_zero;
    logic cont;
    logic curk_ge_len;
    logic ptrk_ge_len;
    logic pos_ge_len;
  } dp_flags_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  localparam ucode_t UW_NOP = '{
    cond: C_NEVER, target: '0, cur_op: CUR_HOLD, len_op: LEN_HOLD,
    ptr_op: PTR_HOLD, k_op: K_HOLD, e_inc: 1'b0, rd_sel: RD_NONE,
    wr_sel: WR_NONE, st_en: 1'b0, st_val: ST_DONE, rb_load: 1'b0, fin: 1'b0
  };

  // Microprogram entry points and labels
  localparam uaddr_t UA_DONE   = 6'd0;
  localparam uaddr_t UA_INS    = 6'd1;
  localparam uaddr_t UA_INS_FL = 6'd2;
  localparam uaddr_t UA_INS_CK = 6'd3;
  localparam uaddr_t UA_INS_RD = 6'd4;
  localparam uaddr_t UA_INS_WR = 6'd5;
  localparam uaddr_t UA_INS_EB = 6'd6;
  localparam uaddr_t UA_INS_UP = 6'd7;
  localparam uaddr_t UA_SR     = 6'd8;
  localparam uaddr_t UA_SR_CK  = 6'd9;
  localparam uaddr_t UA_SR_ADV = 6'd10;
  localparam uaddr_t UA_RGT    = 6'd11;
  localparam uaddr_t UA_RGT_GO = 6'd12;
  localparam uaddr_t UA_LFT    = 6'd13;
  localparam uaddr_t UA_LFT_GO = 6'd14;
  localparam uaddr_t UA_LL     = 6'd15;
  localparam uaddr_t UA_LL_CK  = 6'd16;
  localparam uaddr_t UA_LL_ADV = 6'd17;
  localparam uaddr_t UA_BSP    = 6'd18;
  localparam uaddr_t UA_BSP_GO = 6'd19;
  localparam uaddr_t UA_BL     = 6'd20;
  localparam uaddr_t UA_BL_CK  = 6'd21;
  localparam uaddr_t UA_BL_ADV = 6'd22;
  localparam uaddr_t UA_DEL    = 6'd23;
  localparam uaddr_t UA_RM     = 6'd24;
  localparam uaddr_t UA_RMC    = 6'd25;
  localparam uaddr_t UA_RMC_CK = 6'd26;
  localparam uaddr_t UA_RMC_K  = 6'd27;
  localparam uaddr_t UA_RS     = 6'd28;
  localparam uaddr_t UA_RSL    = 6'd29;
  localparam uaddr_t UA_RSL_WR = 6'd30;
  localparam uaddr_t UA_RE     = 6'd31;
  localparam uaddr_t UA_SET    = 6'd32;
  localparam uaddr_t UA_RD     = 6'd33;
  localparam uaddr_t UA_RD_LD  = 6'd34;
  localparam uaddr_t UA_COUNT  = 6'd35;

  // Entry point of each command
  function automatic uaddr_t dispatch(cmd_t cmd);
    uaddr_t a;
    unique case (cmd)
      CMD_INSERT:    a = UA_INS;
      CMD_LEFT:      a = UA_LFT;
      CMD_RIGHT:     a = UA_RGT;
      CMD_BACKSPACE: a = UA_BSP;
      CMD_DELETE:    a = UA_DEL;
      CMD_SET_CUR:   a = UA_SET;
      CMD_READ:      a = UA_RD;
      CMD_NOTHING:   a = UA_DONE;
      default:       a = UA_DONE;
    endcase
    return a;
  endfunction

  // Control store
  function automatic ucode_t ucode_rom(uaddr_t a);
    ucode_t w;
    w = UW_NOP;
    unique case (a)
      UA_DONE: w.fin = 1'b1;
      // insert: reject, make room, write the encoded bytes, step right
      UA_INS: begin
        w.cond = C_N_ZERO; w.target = UA_DONE; w.st_en = 1'b1; w.st_val = ST_INVALID;
      end
      UA_INS_FL: begin
        w.cond = C_FULL; w.target = UA_DONE; w.st_en = 1'b1; w.st_val = ST_FULL;
        w.ptr_op = PTR_LOAD_LEN;
      end
      UA_INS_CK: begin
        w.cond = C_PTR_EQ_CUR; w.target = UA_INS_EB;
      end
      UA_INS_RD: begin
        w.ptr_op = PTR_DEC; w.rd_sel = RD_PTR_M1;
      end
      UA_INS_WR: begin
        w.wr_sel = WR_PTRK_RD; w.cond = C_PTR_NE_CUR; w.target = UA_INS_RD;
      end
      UA_INS_EB: begin
        w.wr_sel = WR_CURE_ENC; w.e_inc = 1'b1; w.cond = C_E_NE_N; w.target = UA_INS_EB;
      end
      UA_INS_UP: begin
        w.len_op = LEN_ADD_K; w.cur_op = CUR_INC; w.cond = C_ALWAYS; w.target = UA_SR;
      end
      // skip continuation bytes to the right
      UA_SR: begin
        w.cond = C_CUR_GE_LEN; w.target = UA_DONE; w.rd_sel = RD_CUR;
      end
      UA_SR_CK: begin
        w.cond = C_NOT_CONT; w.target = UA_DONE;
      end
      UA_SR_ADV: begin
        w.cur_op = CUR_INC; w.cond = C_ALWAYS; w.target = UA_SR;
      end
      // right
      UA_RGT: begin
        w.cond = C_CUR_GE_LEN; w.target = UA_DONE; w.st_en = 1'b1; w.st_val = ST_NOOP;
      end
      UA_RGT_GO: begin
        w.cur_op = CUR_INC; w.cond = C_ALWAYS; w.target = UA_SR;
      end
      // left
      UA_LFT: begin
        w.cond = C_CUR_ZERO; w.target = UA_DONE; w.st_en = 1'b1; w.st_val = ST_NOOP;
      end
      UA_LFT_GO: w.cur_op = CUR_DEC;
      UA_LL: begin
        w.cond = C_CUR_ZERO; w.target = UA_DONE; w.rd_sel = RD_CUR;
      end
      UA_LL_CK: begin
        w.cond = C_NOT_CONT; w.target = UA_DONE;
      end
      UA_LL_ADV: begin
        w.cur_op = CUR_DEC; w.cond = C_ALWAYS; w.target = UA_LL;
      end
      // backspace: step left, then remove the character
      UA_BSP: begin
        w.cond = C_CUR_ZERO; w.target = UA_DONE; w.st_en = 1'b1; w.st_val = ST_NOOP;
      end
      UA_BSP_GO: w.cur_op = CUR_DEC;
      UA_BL: begin
        w.cond = C_CUR_ZERO; w.target = UA_RM; w.rd_sel = RD_CUR;
      end
      UA_BL_CK: begin
        w.cond = C_NOT_CONT; w.target = UA_RM;
      end
      UA_BL_ADV: begin
        w.cur_op = CUR_DEC; w.cond = C_ALWAYS; w.target = UA_BL;
      end
      // delete
      UA_DEL: begin
        w.cond = C_CUR_GE_LEN; w.target = UA_DONE; w.st_en = 1'b1; w.st_val = ST_NOOP;
      end
      // count the character's bytes, then shift the tail down
      UA_RM: w.k_op = K_ONE;
      UA_RMC: begin
        w.cond = C_CURK_GE_LEN; w.target = UA_RS; w.rd_sel = RD_CURK;
      end
      UA_RMC_CK: begin
        w.cond = C_NOT_CONT; w.target = UA_RS;
      end
      UA_RMC_K: begin
        w.k_op = K_INC; w.cond = C_ALWAYS; w.target = UA_RMC;
      end
      UA_RS: w.ptr_op = PTR_LOAD_CUR;
      UA_RSL: begin
        w.cond = C_PTRK_GE_LEN; w.target = UA_RE; w.rd_sel = RD_PTRK;
      end
      UA_RSL_WR: begin
        w.wr_sel = WR_PTR_RD; w.ptr_op = PTR_INC; w.cond = C_ALWAYS; w.target = UA_RSL;
      end
      UA_RE: begin
        w.len_op = LEN_SUB_K; w.cond = C_ALWAYS; w.target = UA_DONE;
      end
      // set cursor
      UA_SET: begin
        w.cur_op = CUR_SET_POS; w.cond = C_ALWAYS; w.target = UA_DONE;
      end
      // read byte
      UA_RD: begin
        w.cond = C_POS_GE_LEN; w.target = UA_DONE; w.rd_sel = RD_POS;
      end
      UA_RD_LD: begin
        w.rb_load = 1'b1; w.cond = C_ALWAYS; w.target = UA_DONE;
      end
      default: w.fin = 1'b1;
    endcase
    return w;
  endfunction

  // Encode a scalar as UTF-8; a length of zero marks an invalid value
  function automatic enc_t utf8_encode(logic [CP_W-1:0] cp);
    enc_t r;
    r = '0;
    if (cp < CP_LIM_1B) begin
      r.n    = 3'd1;
      r.b[0] = {1'b0, cp[6:0]};
    end else if (cp < CP_LIM_2B) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < CP_LIM_3B) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else if (cp < CP_LIM_4B) begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ule_ram.sv
// ----------------------------------------------------------------------------
// ule_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ule_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: rtl/core/ule_seq.sv
// ----------------------------------------------------------------------------
// ule_seq
// Microprogram sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module ule_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ule_pkg::cmd_t      cmd,
  input  logic               out_free,
  input  ule_pkg::dp_flags_t flags,
  output ule_pkg::dp_ctrl_t  ctrl,
  output logic               idle,
  output logic               finish
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state_r;
  ule_pkg::uaddr_t  upc_r;
  ule_pkg::ucode_t  word;
  logic             taken;

  // Fetch the current control word
  always_comb begin
    word = (state_r == S_RUN) ? ule_pkg::ucode_rom(upc_r) : ule_pkg::UW_NOP;
  end

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      ule_pkg::C_NEVER:       taken = 1'b0;
      ule_pkg::C_ALWAYS:      taken = 1'b1;
      ule_pkg::C_N_ZERO:      taken = flags.n_zero;
      ule_pkg::C_FULL:        taken = flags.full;
      ule_pkg::C_PTR_EQ_CUR:  taken = flags.ptr_eq_cur;
      ule_pkg::C_PTR_NE_CUR:  taken = !flags.ptr_eq_cur;
      ule_pkg::C_E_NE_N:      taken = !flags.e_last;
      ule_pkg::C_CUR_GE_LEN:  taken = flags.cur_ge_len;
      ule_pkg::C_CUR_ZERO:    taken = flags.cur_zero;
      ule_pkg::C_NOT_CONT:    taken = !flags.cont;
      ule_pkg::C_CURK_GE_LEN: taken = flags.curk_ge_len;
      ule_pkg::C_PTRK_GE_LEN: taken = flags.ptrk_ge_len;
      ule_pkg::C_POS_GE_LEN:  taken = flags.pos_ge_len;
      default:                taken = 1'b0;
    endcase
  end

  assign ctrl.start = start;
  assign ctrl.taken = taken;
  assign ctrl.word  = word;
  assign idle       = (state_r == S_IDLE);
  assign finish     = (state_r == S_RUN) && word.fin && out_free;

  // Step counter and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      upc_r   <= ule_pkg::UA_DONE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            upc_r   <= ule_pkg::dispatch(cmd);
          end
        end
        S_RUN: begin
          if (word.fin) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else if (taken) begin
            upc_r <= word.target;
          end else begin
            upc_r <= upc_r + 6'd1;
          end
        end
      endcase
    end
  end

  // Program counter stays inside the control store while running
  a_upc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (upc_r < ule_pkg::UA_COUNT))
    else $error("step counter outside the program");

  // A new command is never taken while a program runs
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("command started while busy");

endmodule

FILE: rtl/core/ule_dp.sv
// ----------------------------------------------------------------------------
// ule_dp
// Datapath: cursor, length, scan pointer, byte count, encoder and text store.
// ----------------------------------------------------------------------------
module ule_dp #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ule_pkg::dp_ctrl_t           ctrl,
  input  logic [ule_pkg::CP_W-1:0]    code_point,
  input  logic [ule_pkg::POS_W-1:0]   position,
  output ule_pkg::dp_flags_t          flags,
  output logic [ule_pkg::OUT_W-1:0]   cursor,
  output logic [ule_pkg::OUT_W-1:0]   length,
  output logic [7:0]                  read_byte,
  output ule_pkg::status_t            status
);

  localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned PW = (LW > ule_pkg::POS_W) ? LW : ule_pkg::POS_W;

  ule_pkg::ucode_t   w;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     ptr_r, ptr_nxt;
  logic [LW-1:0]     k_r, k_nxt;
  logic [1:0]        e_r;
  logic [3:0][7:0]   enc_r;
  logic [ule_pkg::POS_W-1:0] pos_r;
  ule_pkg::status_t  status_r;
  logic [7:0]        rbyte_r;
  ule_pkg::enc_t     enc;
  logic [LW:0]       curk_sum, ptrk_sum;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign w   = ctrl.word;
  assign enc = ule_pkg::utf8_encode(code_point);

  // Conditions for the sequencer
  assign curk_sum = {1'b0, cur_r} + {1'b0, k_r};
  assign ptrk_sum = {1'b0, ptr_r} + {1'b0, k_r};

  always_comb begin
    flags.n_zero      = (k_r == '0);
    flags.full        = ({1'b0, len_r} + {1'b0, k_r}) > (LW + 1)'(BUFFER_BYTES);
    flags.ptr_eq_cur  = (ptr_r == cur_r);
    flags.e_last      = ((LW'(e_r) + LW'(1)) == k_r);
    flags.cur_ge_len  = (cur_r >= len_r);
    flags.cur_zero    = (cur_r == '0);
    flags.cont        = ((ram_rdata & ule_pkg::CONT_MASK) == ule_pkg::CONT_TAG);
    flags.curk_ge_len = (curk_sum >= {1'b0, len_r});
    flags.ptrk_ge_len = (ptrk_sum >= {1'b0, len_r});
    flags.pos_ge_len  = (PW'(pos_r) >= PW'(len_r));
  end

  // Next cursor
  always_comb begin
    unique case (w.cur_op)
      ule_pkg::CUR_HOLD:    cur_nxt = cur_r;
      ule_pkg::CUR_INC:     cur_nxt = cur_r + LW'(1);
      ule_pkg::CUR_DEC:     cur_nxt = cur_r - LW'(1);
      ule_pkg::CUR_SET_POS: cur_nxt = flags.pos_ge_len ? len_r : LW'(pos_r);
    endcase
  end

  // Next length
  always_comb begin
    case (w.len_op)
      ule_pkg::LEN_ADD_K: len_nxt = len_r + k_r;
      ule_pkg::LEN_SUB_K: len_nxt = len_r - k_r;
      default:            len_nxt = len_r;
    endcase
  end

  // Next scan pointer
  always_comb begin
    case (w.ptr_op)
      ule_pkg::PTR_LOAD_LEN: ptr_nxt = len_r;
      ule_pkg::PTR_LOAD_CUR: ptr_nxt = cur_r;
      ule_pkg::PTR_DEC:      ptr_nxt = ptr_r - LW'(1);
      ule_pkg::PTR_INC:      ptr_nxt = ptr_r + LW'(1);
      default:               ptr_nxt = ptr_r;
    endcase
  end

  // Next byte count: encoded length at start, removal count later
  always_comb begin
    if (ctrl.start) begin
      k_nxt = LW'(enc.n);
    end else begin
      case (w.k_op)
        ule_pkg::K_ONE: k_nxt = LW'(1);
        ule_pkg::K_INC: k_nxt = k_r + LW'(1);
        default:        k_nxt = k_r;
      endcase
    end
  end

  // Read address
  always_comb begin
    ram_re = (w.rd_sel != ule_pkg::RD_NONE);
    case (w.rd_sel)
      ule_pkg::RD_PTR_M1: ram_raddr = AW'(ptr_r - LW'(1));
      ule_pkg::RD_CUR:    ram_raddr = AW'(cur_r);
      ule_pkg::RD_CURK:   ram_raddr = AW'(curk_sum);
      ule_pkg::RD_PTRK:   ram_raddr = AW'(ptrk_sum);
      ule_pkg::RD_POS:    ram_raddr = AW'(PW'(pos_r));
      default:            ram_raddr = '0;
    endcase
  end

  // Write address and data
  always_comb begin
    ram_we = (w.wr_sel != ule_pkg::WR_NONE);
    unique case (w.wr_sel)
      ule_pkg::WR_NONE: begin
        ram_waddr = '0;
        ram_wdata = ram_rdata;
      end
      ule_pkg::WR_PTRK_RD: begin
        ram_waddr = AW'(ptrk_sum);
        ram_wdata = ram_rdata;
      end
      ule_pkg::WR_CURE_ENC: begin
        ram_waddr = AW'(cur_r + LW'(e_r));
        ram_wdata = enc_r[e_r];
      end
      ule_pkg::WR_PTR_RD: begin
        ram_waddr = AW'(ptr_r);
        ram_wdata = ram_rdata;
      end
    endcase
  end

  // Cursor and length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      len_r <= '0;
    end else begin
      cur_r <= cur_nxt;
      len_r <= len_nxt;
    end
  end

  // Working registers: latch the command at start, then follow the program
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    k_r   <= k_nxt;
    if (ctrl.start) begin
      e_r      <= 2'd0;
      enc_r    <= enc.b;
      pos_r    <= position;
      status_r <= ule_pkg::ST_DONE;
      rbyte_r  <= 8'd0;
    end else begin
      if (w.e_inc) begin
        e_r <= e_r + 2'd1;
      end
      if (w.st_en && ctrl.taken) begin
        status_r <= w.st_val;
      end
      if (w.rb_load) begin
        rbyte_r <= ram_rdata;
      end
    end
  end

  ule_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_text (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cursor    = ule_pkg::OUT_W'(cur_r);
  assign length    = ule_pkg::OUT_W'(len_r);
  assign read_byte = rbyte_r;
  assign status    = status_r;

  // Cursor never passes the end of the text
  a_cur_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r)
    else $error("cursor beyond text length");

  // Text never exceeds the store
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(BUFFER_BYTES))
    else $error("text length beyond capacity");

endmodule

FILE: rtl/core/utf8_line_edit_buffer.sv
// ----------------------------------------------------------------------------
// utf8_line_edit_buffer
// Line-edit byte store for UTF-8 text with a cursor, run by a microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   One command per input transaction on in_*: insert, left, right, backspace,
//   delete, set cursor, read byte or nothing. Each command gives exactly one
//   result transaction on out_* carrying cursor, length, read byte and status.
//   in_tready is high while no command is in progress; a command is taken at
//   the edge where in_tvalid and in_tready are both high.
// Operation:
//   A short microprogram runs per command; left and right take longer for
//   each continuation byte skipped. Insert, delete and backspace move the
//   tail through the single text RAM port pair, reading then writing each
//   byte, so their time grows with length - cursor. One command is worked on
//   at a time; the next is taken from the cycle the result appears.
// Reset:
//   rst_n low clears cursor and length to zero; the text RAM is not cleared,
//   since no byte at or above the length is ever read back.
// Stall:
//   The result sits in an output register. A new command is taken while it
//   waits; that command's program then holds at its last step until the
//   register is free.
// ----------------------------------------------------------------------------
module utf8_line_edit_buffer #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[2:0], code_point[23:3], position[34:24], zero[39:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // cursor[10:0], length[21:11], read_byte[29:22],
                                  // status[31:30]
);

  ule_pkg::dp_ctrl_t              ctrl;
  ule_pkg::dp_flags_t             flags;
  logic                           idle;
  logic                           finish;
  logic                           start;
  logic                           out_free;
  logic [ule_pkg::OUT_W-1:0]      res_cursor, res_length;
  logic [7:0]                     res_byte;
  ule_pkg::status_t               res_status;
  logic                           out_tvalid_r;
  logic [31:0]                    out_tdata_r;

  assign in_tready = idle;
  assign start     = in_tvalid && idle;
  assign out_free  = !out_tvalid_r || out_tready;

  ule_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd      (ule_pkg::cmd_t'(in_tdata[2:0])),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl),
    .idle     (idle),
    .finish   (finish)
  );

  ule_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .code_point (in_tdata[23:3]),
    .position   (in_tdata[34:24]),
    .flags      (flags),
    .cursor     (res_cursor),
    .length     (res_length),
    .read_byte  (res_byte),
    .status     (res_status)
  );

  // Output register: load on finish, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (finish) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_tdata_r <= {res_status, res_byte, res_length, res_cursor};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!out_tvalid_r || out_tready))
    else $error("result overwrote a pending transaction");

endmodule

FILE: sim/utf8_line_edit_buffer_tb.sv
// ----------------------------------------------------------------------------
// utf8_line_edit_buffer_tb
// Self-checking bench for the UTF-8 line-edit buffer. A queue of key commands
// feeds a clocked driver with random gaps. A clocked monitor with random
// back-pressure predicts each command's cursor, length, read byte and status
// from its own copy of the text, then checks every result transaction in
// order. Stimulus runs from a directed opener through mixed editing, filling
// the store to capacity and editing while full, to removal-heavy editing.
// ----------------------------------------------------------------------------
module utf8_line_edit_buffer_tb;

  localparam int BUFFER_BYTES = 1024;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int TAIL_CYCLES  = 64;
  localparam int SHOW_LIMIT   = 10;

  typedef struct {
    ule_pkg::cmd_t                 cmd;
    logic [ule_pkg::CP_W-1:0]      cp;
    logic [ule_pkg::POS_W-1:0]     pos;
  } edit_key_t;

  typedef struct {
    logic [ule_pkg::OUT_W-1:0] cursor;
    logic [ule_pkg::OUT_W-1:0] length;
    logic [7:0]                rbyte;
    ule_pkg::status_t          status;
  } line_view_t;

  typedef enum int {GEN_MIX, GEN_FILL, GEN_FULL, GEN_DRAIN} gen_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // cmd[2:0], code_point[23:3], position[34:24], zero[39:35]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // cursor[10:0], length[21:11], read_byte[29:22],
                                  // status[31:30]

  edit_key_t  pending_keys[$];
  line_view_t due_results[$];

  // Predicted line state
  logic [7:0] line_text [BUFFER_BYTES];
  int         line_len;
  int         line_cur;

  int fault_count;
  int cyc_count;
  int gap_left;
  int stall_left;

  // No idling on either side for a quarter of the run
  wire calm = (cyc_count[11:10] == 2'b11);

  utf8_line_edit_buffer #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit byte_is_cont(int idx);
    return idx < line_len &&
           (line_text[idx] & ule_pkg::CONT_MASK) == ule_pkg::CONT_TAG;
  endfunction

  function automatic bit step_fwd();
    if (line_cur >= line_len) begin
      line_cur = line_len;
      return 1'b0;
    end
    do line_cur++; while (line_cur < line_len && byte_is_cont(line_cur));
    return 1'b1;
  endfunction

  function automatic bit step_back();
    if (line_cur == 0) return 1'b0;
    do line_cur--; while (line_cur > 0 && byte_is_cont(line_cur));
    return 1'b1;
  endfunction

  function automatic void drop_byte(int at);
    if (at >= line_len) return;
    for (int i = at; i < line_len - 1; i++) line_text[i] = line_text[i + 1];
    line_len--;
  endfunction

  // Remove the lead byte at the cursor and the continuation bytes after it
  function automatic void drop_char();
    int at;
    at = line_cur;
    drop_byte(at);
    while (byte_is_cont(at)) drop_byte(at);
  endfunction

  // Encode a scalar; n of zero marks a value past the Unicode range
  function automatic ule_pkg::enc_t encode_scalar(logic [ule_pkg::CP_W-1:0] cp);
    ule_pkg::enc_t e;
    e = '0;
    if (cp < ule_pkg::CP_LIM_1B) begin
      e.n = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < ule_pkg::CP_LIM_2B) begin
      e.n = 3'd2;
      e.b[0] = 8'(cp >> 6) | 8'hC0;
      e.b[1] = (8'(cp) & 8'h3F) | ule_pkg::CONT_TAG;
    end else if (cp < ule_pkg::CP_LIM_3B) begin
      e.n = 3'd3;
      e.b[0] = 8'(cp >> 12) | 8'hE0;
      e.b[1] = (8'(cp >> 6) & 8'h3F) | ule_pkg::CONT_TAG;
      e.b[2] = (8'(cp) & 8'h3F) | ule_pkg::CONT_TAG;
    end else if (cp < ule_pkg::CP_LIM_4B) begin
      e.n = 3'd4;
      e.b[0] = 8'(cp >> 18) | 8'hF0;
      e.b[1] = (8'(cp >> 12) & 8'h3F) | ule_pkg::CONT_TAG;
      e.b[2] = (8'(cp >> 6) & 8'h3F) | ule_pkg::CONT_TAG;
      e.b[3] = (8'(cp) & 8'h3F) | ule_pkg::CONT_TAG;
    end
    return e;
  endfunction

  // Apply one key to the predicted line and return the view it should give
  function automatic line_view_t apply_edit(edit_key_t k);
    line_view_t    v;
    ule_pkg::enc_t e;
    int            n;
    v.rbyte  = 8'h00;
    v.status = ule_pkg::ST_DONE;
    if (line_cur > line_len) line_cur = line_len;
    case (k.cmd)
      ule_pkg::CMD_INSERT: begin
        e = encode_scalar(k.cp);
        n = int'(e.n);
        if (n == 0) begin
          v.status = ule_pkg::ST_INVALID;
        end else if (line_len + n > BUFFER_BYTES) begin
          v.status = ule_pkg::ST_FULL;
        end else begin
          for (int i = line_len - 1; i >= line_cur; i--) line_text[i + n] = line_text[i];
          for (int i = 0; i < n; i++) line_text[line_cur + i] = e.b[i];
          line_len += n;
          void'(step_fwd());
        end
      end
      ule_pkg::CMD_LEFT:  if (!step_back()) v.status = ule_pkg::ST_NOOP;
      ule_pkg::CMD_RIGHT: if (!step_fwd()) v.status = ule_pkg::ST_NOOP;
      ule_pkg::CMD_BACKSPACE: begin
        if (line_cur == 0) begin
          v.status = ule_pkg::ST_NOOP;
        end else begin
          void'(step_back());
          drop_char();
        end
      end
      ule_pkg::CMD_DELETE: begin
        if (line_cur >= line_len) v.status = ule_pkg::ST_NOOP;
        else drop_char();
      end
      ule_pkg::CMD_SET_CUR: line_cur = (int'(k.pos) > line_len) ? line_len : int'(k.pos);
      ule_pkg::CMD_READ:    if (int'(k.pos) < line_len) v.rbyte = line_text[k.pos];
      default: ;
    endcase
    v.cursor = ule_pkg::OUT_W'(line_cur);
    v.length = ule_pkg::OUT_W'(line_len);
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic edit_key_t make_key(ule_pkg::cmd_t cmd, int cp, int pos);
    edit_key_t k;
    k.cmd = cmd;
    k.cp  = ule_pkg::CP_W'(cp);
    k.pos = ule_pkg::POS_W'(pos);
    return k;
  endfunction

  // Scalar of a given encoded size: 0..3 for 1..4 bytes, 4 for out of range
  function automatic int rand_cp(int size_class);
    case (size_class)
      0:       return $urandom_range(0, 'h7F);
      1:       return $urandom_range('h80, 'h7FF);
      2:       return $urandom_range('h800, 'hFFFF);
      3:       return $urandom_range('h10000, 'h10FFFF);
      default: return $urandom_range('h110000, 'h1FFFFF);
    endcase
  endfunction

  function automatic int rand_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 40);
    if (r < 80) return $urandom_range(0, 1100);
    return $urandom_range(0, 2047);
  endfunction

  function automatic int rand_class();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 50) return 1;
    if (r < 70) return 2;
    if (r < 95) return 3;
    return 4;
  endfunction

  function automatic edit_key_t rand_key(gen_mode_t mode);
    int            r;
    int            junk;
    ule_pkg::cmd_t c;
    r    = $urandom_range(0, 99);
    junk = $urandom_range(0, 'h1FFFFF);
    case (mode)
      GEN_FILL: begin
        if (r < 96)      return make_key(ule_pkg::CMD_INSERT, rand_cp(3), rand_pos());
        else if (r < 98) c = ule_pkg::CMD_READ;
        else if (r < 99) return make_key(ule_pkg::CMD_SET_CUR, junk, 2047);
        else             c = ule_pkg::CMD_LEFT;
      end
      GEN_DRAIN: begin
        if (r < 35)      c = ule_pkg::CMD_BACKSPACE;
        else if (r < 60) c = ule_pkg::CMD_DELETE;
        else if (r < 75) c = ule_pkg::CMD_SET_CUR;
        else if (r < 80) c = ule_pkg::CMD_LEFT;
        else if (r < 85) c = ule_pkg::CMD_RIGHT;
        else if (r < 95) c = ule_pkg::CMD_READ;
        else return make_key(ule_pkg::CMD_INSERT, rand_cp(rand_class()), rand_pos());
      end
      default: begin
        // Mixed editing; the full store sees fewer inserts
        if (r < (mode == GEN_FULL ? 30 : 45))
          return make_key(ule_pkg::CMD_INSERT, rand_cp(rand_class()), rand_pos());
        else if (r < 55) c = ule_pkg::CMD_LEFT;
        else if (r < 64) c = ule_pkg::CMD_RIGHT;
        else if (r < 74) c = ule_pkg::CMD_BACKSPACE;
        else if (r < 84) c = ule_pkg::CMD_DELETE;
        else if (r < 90) c = ule_pkg::CMD_SET_CUR;
        else if (r < 97) c = ule_pkg::CMD_READ;
        else             c = ule_pkg::CMD_NOTHING;
      end
    endcase
    return make_key(c, junk, rand_pos());
  endfunction

  // Hold until every queued key is taken and every result has come back
  task automatic drain_wait();
    do @(negedge clk);
    while (pending_keys.size() != 0 || in_tvalid || due_results.size() != 0);
  endtask

  initial begin
    int rounds;
    int room;
    fault_count = 0;
    line_len    = 0;
    line_cur    = 0;
    for (int i = 0; i < BUFFER_BYTES; i++) line_text[i] = 8'h00;

    // Boundaries of the empty line
    pending_keys.push_back(make_key(ule_pkg::CMD_NOTHING, 'h1FFFFF, 2047));
    pending_keys.push_back(make_key(ule_pkg::CMD_LEFT, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_RIGHT, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_BACKSPACE, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_DELETE, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_READ, 0, 2047));
    pending_keys.push_back(make_key(ule_pkg::CMD_SET_CUR, 0, 2047));
    // Out-of-range scalars, then the edges of every encoded size
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h110000, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h1FFFFF, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h7F, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h80, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h7FF, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h800, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'hD800, 0));    // surrogate
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'hFFFF, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h10000, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h10FFFF, 0));
    // Cursor parked on a continuation byte, then insert there
    pending_keys.push_back(make_key(ule_pkg::CMD_SET_CUR, 0, 3));
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, 'h41, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_LEFT, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_BACKSPACE, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_SET_CUR, 0, 9));
    pending_keys.push_back(make_key(ule_pkg::CMD_DELETE, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_READ, 0, 2));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    drain_wait();

    for (int i = 0; i < 12; i++) pending_keys.push_back(rand_key(GEN_MIX));
    drain_wait();

    // Fill towards capacity in short bursts, checking the length between them
    rounds = 0;
    while (line_len < BUFFER_BYTES - 3 && rounds < 60) begin
      for (int i = 0; i < 10; i++) pending_keys.push_back(rand_key(GEN_FILL));
      drain_wait();
      rounds++;
    end

    // Refuse a character that no longer fits, then top up to the last byte
    pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, rand_cp(3), 0));
    drain_wait();
    while (line_len < BUFFER_BYTES) begin
      room = BUFFER_BYTES - line_len;
      pending_keys.push_back(make_key(ule_pkg::CMD_INSERT,
                                      rand_cp(room >= 4 ? 3 : room - 1), 0));
      drain_wait();
    end

    // Full store: every size refused, then the far end of the cursor range
    for (int c = 0; c < 5; c++)
      pending_keys.push_back(make_key(ule_pkg::CMD_INSERT, rand_cp(c), 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_SET_CUR, 0, BUFFER_BYTES));
    pending_keys.push_back(make_key(ule_pkg::CMD_RIGHT, 0, 0));
    pending_keys.push_back(make_key(ule_pkg::CMD_READ, 0, BUFFER_BYTES - 1));
    pending_keys.push_back(make_key(ule_pkg::CMD_READ, 0, BUFFER_BYTES));
    pending_keys.push_back(make_key(ule_pkg::CMD_LEFT, 0, 0));
    for (int i = 0; i < 8; i++) pending_keys.push_back(rand_key(GEN_FULL));
    drain_wait();

    for (int i = 0; i < 14; i++) pending_keys.push_back(rand_key(GEN_DRAIN));
    drain_wait();

    // Watch for stray results before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("utf8_line_edit_buffer_tb: done, clean");
    end else begin
      $display("utf8_line_edit_buffer_tb: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // Present the next key once the current transaction is taken, after a gap
  always @(posedge clk) begin
    edit_key_t k;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_keys.size() != 0) begin
        k = pending_keys.pop_front();
        in_tdata  <= {5'b0, k.pos, k.cp, k.cmd};
        in_tvalid <= 1'b1;
        gap_left  <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // Check each result transaction, then predict for a newly taken key
  always @(posedge clk) begin
    line_view_t want;
    line_view_t got;
    edit_key_t  k;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.cursor = out_tdata[10:0];
        got.length = out_tdata[21:11];
        got.rbyte  = out_tdata[29:22];
        got.status = ule_pkg::status_t'(out_tdata[31:30]);
        if (due_results.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOW_LIMIT)
            $display("unexpected result: cursor %0d length %0d byte %h status %0d",
                     got.cursor, got.length, got.rbyte, got.status);
        end else begin
          want = due_results.pop_front();
          if (got.cursor !== want.cursor || got.length !== want.length ||
              got.rbyte !== want.rbyte || got.status !== want.status) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT)
              $display("mismatch: cursor %0d/%0d length %0d/%0d byte %h/%h status %0d/%0d",
                       want.cursor, got.cursor, want.length, got.length,
                       want.rbyte, got.rbyte, want.status, got.status);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        k.cmd = ule_pkg::cmd_t'(in_tdata[2:0]);
        k.cp  = in_tdata[23:3];
        k.pos = in_tdata[34:24];
        due_results.push_back(apply_edit(k));
      end
      // Back-pressure: occasional stalls of random length
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("utf8_line_edit_buffer_tb: done, errors");
      $finish;
    end
  end

  initial cyc_count = 0;

endmodule

FILE: files.f
rtl/core/ule_pkg.sv
rtl/core/ule_ram.sv
rtl/core/ule_seq.sv
rtl/core/ule_dp.sv
rtl/core/utf8_line_edit_buffer.sv
sim/utf8_line_edit_buffer_tb.sv
